// ===== hw/rtl/mcmm_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI message mapper package
// Shared constants for the controller message mapper.
// ----------------------------------------------------------------------------
package mcmm_pkg;

  localparam int BUTTONS = 4;
  localparam int BTN_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int SEL_W   = $clog2(BUTTONS + 1);

  localparam logic [7:0] ST_CC         = 8'hb0;
  localparam logic [7:0] ST_PC         = 8'hc0;
  localparam logic [7:0] CC_VOLUME     = 8'h07;
  localparam logic [7:0] CC_EXPR       = 8'h0b;
  localparam logic [7:0] CC_EXPR_OUT   = 8'h04;
  localparam logic [7:0] CC_BUTTON0    = 8'h14;
  localparam logic [7:0] CC_TAP        = 8'h40;
  localparam logic [7:0] TAP_VALUE     = 8'h7f;
  localparam logic [7:0] CC_SWITCH     = 8'h66;
  localparam logic [7:0] CC_SWITCH_OUT = 8'h2b;
  localparam logic [7:0] SWITCH_ON     = 8'h40;

  localparam logic [6:0] THRESHOLD_RESET = 7'd2;

  localparam logic SRC_CTL = 1'b0;
  localparam logic SRC_AMP = 1'b1;

endpackage

// ===== hw/rtl/midi_controller_message_mapper_core.sv =====
// ----------------------------------------------------------------------------
// MIDI controller message mapper
// Assembles per-source MIDI messages and maps controller messages to amp bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one raw MIDI byte per request; tuser selects the source
//   (0 foot controller, 1 amp). m_axis: output MIDI bytes, tlast on the final
//   byte of each emitted message. cfg: write of the 7-bit pedal threshold,
//   always ready.
// Output: a byte that completes a message shows its first output byte on
//   m_axis in the cycle after it is accepted; the message then drains one
//   byte per cycle, while m_axis_tready is high, from a three-byte result buffer.
// Throughput: bytes that emit nothing are taken every cycle. A byte that
//   emits a message holds s_axis off while the result buffer drains through
//   the single output byte lane; input is taken again as the last byte of
//   that message leaves.
// Reset: parsers idle, pedal memories and bank zero, no button selected,
//   threshold 2, result buffer empty.
// Stall: while m_axis_tready is low the current byte holds and no new input
//   is taken while the buffer holds anything.
// ----------------------------------------------------------------------------
module midi_controller_message_mapper_core
  import mcmm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] func
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic [6:0]       pedal_threshold;
  logic [7:0]       ctl_status, ctl_first_data, amp_status;
  logic [1:0]       ctl_count, amp_count;
  logic [7:0]       volume_sent, expression_sent, bank_number;
  logic [SEL_W-1:0] selected_button;

  logic [7:0]       ctl_status_next, ctl_first_data_next, amp_status_next;
  logic [1:0]       ctl_count_next, amp_count_next;
  logic [7:0]       volume_sent_next, expression_sent_next, bank_number_next;
  logic [SEL_W-1:0] selected_button_next;

  // result buffer, byte 0 is on the bus
  logic [7:0] msg_byte [3];
  logic [1:0] msg_cnt;
  logic [7:0] new_byte [3];
  logic [1:0] new_cnt;

  logic accept, drain;
  logic [7:0] cc, val, diff_vol, diff_expr, amp_idx, pc_byte;
  logic [BTN_W-1:0] btn_idx;
  logic is_button;

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = (msg_cnt != 2'd0);
  assign m_axis_tdata  = msg_byte[0];
  assign m_axis_tlast  = (msg_cnt == 2'd1);
  assign drain         = m_axis_tvalid & m_axis_tready;
  // take a new byte once the buffer is empty or its last byte leaves now
  assign s_axis_tready = (msg_cnt == 2'd0) || ((msg_cnt == 2'd1) && m_axis_tready);
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign cc  = ctl_first_data;
  assign val = s_axis_tdata;
  assign diff_vol  = (val >= volume_sent) ? val - volume_sent : volume_sent - val;
  assign diff_expr = (val >= expression_sent) ? val - expression_sent
                                               : expression_sent - val;
  assign is_button = (cc >= CC_BUTTON0) && (cc < CC_BUTTON0 + 8'(BUTTONS));
  assign btn_idx   = BTN_W'(cc - CC_BUTTON0);
  assign pc_byte   = bank_number * 8'(BUTTONS) + 8'(btn_idx) + 8'd1;
  assign amp_idx   = val - 8'd1;

  always_comb begin
    ctl_status_next      = ctl_status;
    ctl_first_data_next  = ctl_first_data;
    ctl_count_next       = ctl_count;
    amp_status_next      = amp_status;
    amp_count_next       = amp_count;
    volume_sent_next     = volume_sent;
    expression_sent_next = expression_sent;
    bank_number_next     = bank_number;
    selected_button_next = selected_button;
    new_cnt              = 2'd0;
    new_byte[0]          = ST_CC;
    new_byte[1]          = 8'h00;
    new_byte[2]          = 8'h00;

    if (s_axis_tuser == SRC_CTL) begin
      if (ctl_count == 2'd0) begin
        if (val == ST_CC || val == ST_PC) begin
          ctl_status_next = val;
          ctl_count_next  = 2'd1;
        end
      end else if (ctl_status == ST_PC) begin
        ctl_count_next = 2'd0;
      end else if (ctl_count == 2'd1) begin
        ctl_first_data_next = val;
        ctl_count_next      = 2'd2;
      end else begin
        ctl_count_next = 2'd0;
        if (cc == CC_VOLUME) begin
          if (diff_vol >= {1'b0, pedal_threshold}) begin
            volume_sent_next = val;
            new_cnt     = 2'd3;
            new_byte[1] = CC_VOLUME;
            new_byte[2] = val;
          end
        end else if (cc == CC_EXPR) begin
          if (diff_expr >= {1'b0, pedal_threshold}) begin
            expression_sent_next = val;
            new_cnt     = 2'd3;
            new_byte[1] = CC_EXPR_OUT;
            new_byte[2] = val;
          end
        end else if (is_button) begin
          if (val != 8'h00) begin
            if (SEL_W'(btn_idx) != selected_button) begin
              selected_button_next = SEL_W'(btn_idx);
              new_cnt     = 2'd2;
              new_byte[0] = ST_PC;
              new_byte[1] = pc_byte;
            end else begin
              new_cnt     = 2'd3;
              new_byte[1] = CC_TAP;
              new_byte[2] = TAP_VALUE;
            end
          end
        end else if (cc == CC_SWITCH) begin
          new_cnt     = 2'd3;
          new_byte[1] = CC_SWITCH_OUT;
          new_byte[2] = (val != 8'h00) ? SWITCH_ON : 8'h00;
        end
      end
    end else begin
      if (amp_count == 2'd0) begin
        if (val == ST_CC || val == ST_PC) begin
          amp_status_next = val;
          amp_count_next  = 2'd1;
        end
      end else if (amp_status == ST_PC) begin
        bank_number_next     = amp_idx / 8'(BUTTONS);
        selected_button_next = SEL_W'(amp_idx % 8'(BUTTONS));
        amp_count_next       = 2'd0;
      end else if (amp_count == 2'd1) begin
        amp_count_next = 2'd2;
      end else begin
        amp_count_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_threshold <= THRESHOLD_RESET;
      ctl_status      <= 8'h00;
      ctl_first_data  <= 8'h00;
      ctl_count       <= 2'd0;
      amp_status      <= 8'h00;
      amp_count       <= 2'd0;
      volume_sent     <= 8'h00;
      expression_sent <= 8'h00;
      bank_number     <= 8'h00;
      selected_button <= SEL_W'(BUTTONS);
      msg_cnt         <= 2'd0;
    end else begin
      if (cfg_valid) begin
        pedal_threshold <= cfg_data;
      end
      if (accept) begin
        ctl_status      <= ctl_status_next;
        ctl_first_data  <= ctl_first_data_next;
        ctl_count       <= ctl_count_next;
        amp_status      <= amp_status_next;
        amp_count       <= amp_count_next;
        volume_sent     <= volume_sent_next;
        expression_sent <= expression_sent_next;
        bank_number     <= bank_number_next;
        selected_button <= selected_button_next;
        msg_cnt         <= new_cnt;
      end else if (drain) begin
        msg_cnt <= msg_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      msg_byte[0] <= new_byte[0];
      msg_byte[1] <= new_byte[1];
      msg_byte[2] <= new_byte[2];
    end else if (drain) begin
      msg_byte[0] <= msg_byte[1];
      msg_byte[1] <= msg_byte[2];
    end
  end

endmodule

// ===== hw/rtl/mcmm_checker.sv =====
// ----------------------------------------------------------------------------
// MIDI message mapper port checker
// Port-level checks on the output stream and input flow control.
// ----------------------------------------------------------------------------
module mcmm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // input is only taken when the buffer can be refilled this cycle
  a_in_flow: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid || (m_axis_tlast && m_axis_tready))
    else $error("input ready while a message is still pending");

  // a message never breaks off before its last byte
  a_msg_cont: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("message ended without last byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind midi_controller_message_mapper_core mcmm_checker u_mcmm_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
